// ===== rtl/core/hpid_pkg.sv =====
// Shared constants for the heading PID controller with deadband.
`default_nettype none
package hpid_pkg;

   localparam int unsigned RawW    = 16;
   localparam int unsigned MotionW = 2;
   localparam int unsigned ModeW   = 2;
   localparam int unsigned DriveW  = 16;
   localparam int unsigned RegW    = 16;
   localparam int unsigned IndexW  = 3;
   localparam int unsigned ErrW    = 18;
   localparam int unsigned AccW    = 32;
   localparam int unsigned DerivW  = 28;
   localparam int unsigned MulAW   = 33;
   localparam int unsigned MulBW   = 17;
   localparam int unsigned ProdW   = MulAW + MulBW;
   localparam int unsigned SumW    = ProdW + 1;

   // heading = raw * 45 / 32 degrees in Q9.8
   localparam logic signed [MulBW-1:0] HeadScale = 17'sd45;

   // motion codes
   localparam logic [MotionW-1:0] MOTION_STOP = 2'd0;
   localparam logic [MotionW-1:0] MOTION_FWD  = 2'd1;
   localparam logic [MotionW-1:0] MOTION_BACK = 2'd2;

   // result modes
   localparam logic [ModeW-1:0] MODE_IDLE     = 2'd0;
   localparam logic [ModeW-1:0] MODE_STRAIGHT = 2'd1;
   localparam logic [ModeW-1:0] MODE_CORRECT  = 2'd2;

   // register indexes
   localparam logic [IndexW-1:0] REG_GAIN_PROP   = 3'd0;
   localparam logic [IndexW-1:0] REG_GAIN_INTEG  = 3'd1;
   localparam logic [IndexW-1:0] REG_GAIN_DERIV  = 3'd2;
   localparam logic [IndexW-1:0] REG_INTEG_STEP  = 3'd3;
   localparam logic [IndexW-1:0] REG_DERIV_RECIP = 3'd4;
   localparam logic [IndexW-1:0] REG_TARGET      = 3'd5;
   localparam logic [IndexW-1:0] REG_DEAD_ZONE   = 3'd6;

   // register reset values
   localparam logic [RegW-1:0] GainPropRst   = 16'd256;
   localparam logic [RegW-1:0] GainIntegRst  = 16'd0;
   localparam logic [RegW-1:0] GainDerivRst  = 16'd0;
   localparam logic [RegW-1:0] IntegStepRst  = 16'd655;
   localparam logic [RegW-1:0] DerivRecipRst = 16'd25600;
   localparam logic [RegW-1:0] TargetRst     = 16'd0;
   localparam logic [RegW-1:0] DeadZoneRst   = 16'd1280;

endpackage
`default_nettype wire

// ===== rtl/core/heading_pid_with_deadband_top.sv =====
// Heading PID controller with deadband: one shared multiplier under a sequencer.
// A stopped beat goes straight to the result; a beat inside the deadband stops after the
// error check, else the sequencer runs through the gain products. One beat in flight: no new
// beat is taken until the last result is written. Heading scale, integral step, derivative
// scale and the three gain products each take one pass through the single 33x17 multiplier.
// Reset (synchronous, active high) loads the register defaults and clears state.
`default_nettype none
module heading_pid_with_deadband_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [hpid_pkg::RawW-1:0]    req_heading_raw,
   input  wire logic [hpid_pkg::MotionW-1:0]        req_motion,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [hpid_pkg::ModeW-1:0]               rsp_mode,
   output logic signed [hpid_pkg::DriveW-1:0]       rsp_turn_drive,
   input  wire logic                                csr_write,
   input  wire logic [hpid_pkg::IndexW-1:0]         csr_index,
   input  wire logic [hpid_pkg::RegW-1:0]           csr_wdata
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_HEAD = 4'd1;
   localparam logic [3:0] S_ERR  = 4'd2;
   localparam logic [3:0] S_CHK  = 4'd3;
   localparam logic [3:0] S_INT  = 4'd4;
   localparam logic [3:0] S_DER  = 4'd5;
   localparam logic [3:0] S_PROP = 4'd6;
   localparam logic [3:0] S_ISUM = 4'd7;
   localparam logic [3:0] S_DSUM = 4'd8;
   localparam logic [3:0] S_FIN  = 4'd9;

   // configuration registers
   logic [hpid_pkg::RegW-1:0] gain_prop_ff, gain_integ_ff, gain_deriv_ff;
   logic [hpid_pkg::RegW-1:0] integ_step_ff, deriv_recip_ff, target_ff, dead_zone_ff;

   // sequencer and datapath
   logic [3:0]                             state_ff, state_in;
   logic signed [hpid_pkg::RawW-1:0]       raw_ff;
   logic signed [hpid_pkg::ErrW-1:0]       err_ff, err_in;
   logic signed [hpid_pkg::ErrW-1:0]       prev_ff, prev_in;
   logic signed [hpid_pkg::AccW-1:0]       integ_ff, integ_in;
   logic signed [hpid_pkg::DerivW-1:0]     deriv_ff, deriv_in;
   logic signed [hpid_pkg::ProdW-1:0]      prod_ff;
   logic signed [hpid_pkg::SumW-1:0]       sum_ff, sum_in;
   logic [hpid_pkg::ModeW-1:0]             mode_ff, mode_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [hpid_pkg::ModeW-1:0]             rsp_mode_ff, rsp_mode_in;
   logic signed [hpid_pkg::DriveW-1:0]     rsp_drive_ff, rsp_drive_in;

   logic signed [hpid_pkg::MulAW-1:0]      mul_a;
   logic signed [hpid_pkg::MulBW-1:0]      mul_b;
   logic signed [hpid_pkg::ProdW-1:0]      mul_p;

   logic                                   req_take;
   logic                                   out_free;
   logic signed [hpid_pkg::ErrW-2:0]       heading;
   logic signed [hpid_pkg::ErrW:0]         err_wide;
   logic signed [hpid_pkg::ErrW:0]         dz_wide;
   logic                                   in_band;
   logic signed [hpid_pkg::ErrW:0]         err_diff;
   logic signed [hpid_pkg::ErrW:0]         integ_inc;
   logic signed [hpid_pkg::AccW:0]         acc_wide;
   logic signed [hpid_pkg::SumW-17:0]      quot;
   logic signed [hpid_pkg::SumW-16:0]      drive_wide;
   logic signed [hpid_pkg::DriveW-1:0]     drive_sat;

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_HEAD: begin
            mul_a = hpid_pkg::MulAW'(raw_ff);
            mul_b = hpid_pkg::HeadScale;
         end
         S_CHK: begin
            mul_a = hpid_pkg::MulAW'(err_ff);
            mul_b = $signed({1'b0, integ_step_ff});
         end
         S_INT: begin
            mul_a = hpid_pkg::MulAW'(err_diff);
            mul_b = $signed({1'b0, deriv_recip_ff});
         end
         S_DER: begin
            mul_a = hpid_pkg::MulAW'(err_ff);
            mul_b = hpid_pkg::MulBW'($signed(gain_prop_ff));
         end
         S_PROP: begin
            mul_a = hpid_pkg::MulAW'(integ_ff);
            mul_b = hpid_pkg::MulBW'($signed(gain_integ_ff));
         end
         S_ISUM: begin
            mul_a = hpid_pkg::MulAW'(deriv_ff);
            mul_b = hpid_pkg::MulBW'($signed(gain_deriv_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // raw*45 fits 22 bits; floor by 32 is an arithmetic shift
   assign heading  = $signed(prod_ff[21:5]);
   assign err_wide = (hpid_pkg::ErrW+1)'($signed(target_ff))
                     - (hpid_pkg::ErrW+1)'(heading);
   assign dz_wide  = $signed({3'b000, dead_zone_ff});
   assign in_band  = ((hpid_pkg::ErrW+1)'(err_ff) <= dz_wide) &&
                     ((hpid_pkg::ErrW+1)'(err_ff) >= -dz_wide);
   assign err_diff = (hpid_pkg::ErrW+1)'(err_ff) - (hpid_pkg::ErrW+1)'(prev_ff);
   assign integ_inc = $signed(prod_ff[34:16]);
   assign acc_wide  = (hpid_pkg::AccW+1)'(integ_ff) + (hpid_pkg::AccW+1)'(integ_inc);

   // truncate toward zero, negate, saturate
   always_comb begin
      quot = $signed(sum_ff[hpid_pkg::SumW-1:16]);
      if (sum_ff[hpid_pkg::SumW-1] && (sum_ff[15:0] != 16'd0)) begin
         quot = quot + (hpid_pkg::SumW-16)'(1);
      end
      drive_wide = -((hpid_pkg::SumW-15)'(quot));
      if (drive_wide > (hpid_pkg::SumW-15)'(32767)) begin
         drive_sat = 16'sh7fff;
      end else if (drive_wide < -(hpid_pkg::SumW-15)'(32768)) begin
         drive_sat = 16'sh8000;
      end else begin
         drive_sat = drive_wide[hpid_pkg::DriveW-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      err_in       = err_ff;
      prev_in      = prev_ff;
      integ_in     = integ_ff;
      deriv_in     = deriv_ff;
      sum_in       = sum_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mode_in  = rsp_mode_ff;
      rsp_drive_in = rsp_drive_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_motion == hpid_pkg::MOTION_FWD || req_motion == hpid_pkg::MOTION_BACK) begin
                  state_in = S_HEAD;
               end else begin
                  mode_in  = hpid_pkg::MODE_IDLE;
                  state_in = S_FIN;
               end
            end
         end
         S_HEAD: state_in = S_ERR;
         S_ERR: begin
            err_in   = err_wide[hpid_pkg::ErrW-1:0];
            state_in = S_CHK;
         end
         S_CHK: begin
            if (in_band) begin
               prev_in  = err_ff;
               mode_in  = hpid_pkg::MODE_STRAIGHT;
               state_in = S_FIN;
            end else begin
               mode_in  = hpid_pkg::MODE_CORRECT;
               state_in = S_INT;
            end
         end
         S_INT: begin
            if (acc_wide[hpid_pkg::AccW] != acc_wide[hpid_pkg::AccW-1]) begin
               integ_in = acc_wide[hpid_pkg::AccW] ? {1'b1, {(hpid_pkg::AccW-1){1'b0}}}
                                                   : {1'b0, {(hpid_pkg::AccW-1){1'b1}}};
            end else begin
               integ_in = acc_wide[hpid_pkg::AccW-1:0];
            end
            state_in = S_DER;
         end
         S_DER: begin
            deriv_in = $signed(prod_ff[35:8]);
            state_in = S_PROP;
         end
         S_PROP: begin
            sum_in   = hpid_pkg::SumW'(prod_ff);
            state_in = S_ISUM;
         end
         S_ISUM: begin
            sum_in   = sum_ff + hpid_pkg::SumW'(prod_ff);
            state_in = S_DSUM;
         end
         S_DSUM: begin
            sum_in   = sum_ff + hpid_pkg::SumW'(prod_ff);
            state_in = S_FIN;
         end
         S_FIN: begin
            // hold until the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mode_in  = mode_ff;
               if (mode_ff == hpid_pkg::MODE_CORRECT) begin
                  rsp_drive_in = drive_sat;
                  prev_in      = err_ff;
               end else begin
                  rsp_drive_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         prev_ff        <= '0;
         integ_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         gain_prop_ff   <= hpid_pkg::GainPropRst;
         gain_integ_ff  <= hpid_pkg::GainIntegRst;
         gain_deriv_ff  <= hpid_pkg::GainDerivRst;
         integ_step_ff  <= hpid_pkg::IntegStepRst;
         deriv_recip_ff <= hpid_pkg::DerivRecipRst;
         target_ff      <= hpid_pkg::TargetRst;
         dead_zone_ff   <= hpid_pkg::DeadZoneRst;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               hpid_pkg::REG_GAIN_PROP:   gain_prop_ff   <= csr_wdata;
               hpid_pkg::REG_GAIN_INTEG:  gain_integ_ff  <= csr_wdata;
               hpid_pkg::REG_GAIN_DERIV:  gain_deriv_ff  <= csr_wdata;
               hpid_pkg::REG_INTEG_STEP:  integ_step_ff  <= csr_wdata;
               hpid_pkg::REG_DERIV_RECIP: deriv_recip_ff <= csr_wdata;
               hpid_pkg::REG_TARGET:      target_ff      <= csr_wdata;
               hpid_pkg::REG_DEAD_ZONE:   dead_zone_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         raw_ff <= req_heading_raw;
      end
      prod_ff      <= mul_p;
      err_ff       <= err_in;
      deriv_ff     <= deriv_in;
      sum_ff       <= sum_in;
      mode_ff      <= mode_in;
      rsp_mode_ff  <= rsp_mode_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mode       = rsp_mode_ff;
   assign rsp_turn_drive = rsp_drive_ff;

`ifndef ASSERT_OFF
   a_drive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode != hpid_pkg::MODE_CORRECT |-> rsp_turn_drive == '0)
      else $error("nonzero drive outside correcting mode");

   a_stop_skips: assert property (@(posedge clock) disable iff (reset)
      req_take && req_motion != hpid_pkg::MOTION_FWD && req_motion != hpid_pkg::MOTION_BACK
      |=> state_ff == S_FIN && mode_ff == hpid_pkg::MODE_IDLE)
      else $error("stopped beat did not go straight to result");

   a_integ_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_INT |=> $stable(integ_ff))
      else $error("integrator changed outside its update step");

   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mode == hpid_pkg::MODE_IDLE || rsp_mode == hpid_pkg::MODE_STRAIGHT
                    || rsp_mode == hpid_pkg::MODE_CORRECT)
      else $error("illegal result mode");
`endif

endmodule
`default_nettype wire
